@@ src/dasi_pkg.sv @@
`default_nettype none
package dasi_pkg;

  localparam int VALUE_W = 64;
  localparam int ACC_W   = 64;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  localparam logic [ACC_W-1:0] LIMIT_WIDE   = 64'h8000_0000_0000_0000;
  localparam logic [ACC_W-1:0] LIMIT_NARROW = 64'h0000_0000_8000_0000;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_SIGN  = 3'd1,
    PH_DIGIT = 3'd2,
    PH_TRAIL = 3'd3,
    PH_FAIL  = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic              is_negative;
    logic [ACC_W-1:0]  accumulator;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{phase: PH_LEAD, is_negative: 1'b0,
                                           accumulator: '0};

endpackage
`default_nettype wire

@@ src/decimal_ascii_to_signed_int.sv @@
// decimal_ascii_to_signed_int
// Parses a signed decimal integer from a stream of ASCII characters.
// Input channel: char_code with in_valid / in_ready, one character per
// transfer; a code of 0 ends the string. Leading and trailing whitespace
// is allowed, an optional '-' may precede the digits.
// Output channel: ok and int_value with out_valid / out_ready, one
// transfer per terminator; int_value is 0 when ok is 0.
// Configuration: narrow_mode is written by cfg_wr_en / cfg_wr_data; the
// user writes it only while the block is idle; the block does not check.
// 0 selects signed 64-bit, 1 signed 32-bit range (result sign-extended).
// Throughput: one character per cycle while in_ready is high. A character
// is registered on transfer and processed by the parse step from the input
// register, which updates the parse state and, for a terminator, loads the
// result register, where the result waits until it is taken.
// When the receiver stalls, a waiting result holds and the block keeps
// taking characters until a second terminator reaches the input register;
// in_ready then drops until the result is taken.
// Reset clears the parse state, empties both registers and sets
// narrow_mode to 0.
`default_nettype none
module decimal_ascii_to_signed_int import dasi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CHAR_W-1:0]   char_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                ok,
  output logic [VALUE_W-1:0]  int_value,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  logic               narrow_mode;
  logic               stage_valid;
  logic [CHAR_W-1:0]  stage_char;
  parse_state_t       state;
  parse_state_t       state_next;
  logic               ok_next;
  logic [VALUE_W-1:0] value_next;
  logic               stage_term;
  logic               advance;

  assign stage_term = (stage_char == CHAR_NUL);
  assign advance    = stage_valid && (!stage_term || !out_valid || out_ready);
  assign in_ready   = !stage_valid || advance;

  dasi_step u_step (
    .cur         (state),
    .char_code   (stage_char),
    .narrow_mode (narrow_mode),
    .nxt         (state_next),
    .ok          (ok_next),
    .value       (value_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_mode <= 1'b0;
      stage_valid <= 1'b0;
      state       <= STATE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        narrow_mode <= cfg_wr_data;
      end
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && stage_term) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_char <= char_code;
    end
    if (advance && stage_term) begin
      ok        <= ok_next;
      int_value <= value_next;
    end
  end

endmodule
`default_nettype wire

@@ src/dasi_step.sv @@
`default_nettype none
module dasi_step import dasi_pkg::*; (
  input  parse_state_t        cur,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic                narrow_mode,
  output parse_state_t        nxt,
  output logic                ok,
  output logic [VALUE_W-1:0]  value
);

  logic              is_space;
  logic              is_digit;
  logic [3:0]        digit;
  logic [ACC_W-1:0]  limit;
  logic [ACC_W+3:0]  acc_ext;
  logic [ACC_W+3:0]  scaled;
  logic              overflow;
  phase_t            digit_phase;

  assign is_space = ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR)) ||
                    (char_code == CHAR_SPACE);
  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit    = char_code[3:0];

  assign limit = (narrow_mode ? LIMIT_NARROW : LIMIT_WIDE) -
                 {{(ACC_W-1){1'b0}}, ~cur.is_negative};

  // acc * 10 + digit, wide enough that it never wraps
  assign acc_ext     = {4'd0, cur.accumulator};
  assign scaled      = (acc_ext << 3) + (acc_ext << 1) + {{ACC_W{1'b0}}, digit};
  assign overflow    = scaled > {4'd0, limit};
  assign digit_phase = overflow ? PH_FAIL : PH_DIGIT;

  always_comb begin
    nxt   = cur;
    ok    = 1'b0;
    value = '0;
    if (char_code == CHAR_NUL) begin
      ok = ((cur.phase == PH_DIGIT) || (cur.phase == PH_TRAIL)) &&
           (cur.accumulator <= limit);
      if (ok) begin
        value = cur.is_negative ? (~cur.accumulator + 1'b1) : cur.accumulator;
      end
      nxt = STATE_RESET;
    end else begin
      case (cur.phase)
        PH_LEAD: begin
          if (is_space) begin
            nxt.phase = PH_LEAD;
          end else if (char_code == CHAR_MINUS) begin
            nxt.is_negative = 1'b1;
            nxt.phase       = PH_SIGN;
          end else if (is_digit) begin
            nxt.phase = digit_phase;
            if (!overflow) begin
              nxt.accumulator = scaled[ACC_W-1:0];
            end
          end else begin
            nxt.phase = PH_FAIL;
          end
        end
        PH_SIGN, PH_DIGIT: begin
          if (is_digit) begin
            nxt.phase = digit_phase;
            if (!overflow) begin
              nxt.accumulator = scaled[ACC_W-1:0];
            end
          end else if (is_space && (cur.phase == PH_DIGIT)) begin
            nxt.phase = PH_TRAIL;
          end else begin
            nxt.phase = PH_FAIL;
          end
        end
        PH_TRAIL: begin
          if (!is_space) begin
            nxt.phase = PH_FAIL;
          end
        end
        default: begin
          nxt.phase = PH_FAIL;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/dasi_checker.sv @@
`default_nettype none
module dasi_checker import dasi_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [CHAR_W-1:0]   char_code,
  input logic                out_valid,
  input logic                out_ready,
  input logic                ok,
  input logic [VALUE_W-1:0]  int_value
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (int_value == '0))
    else $error("failed parse with nonzero value");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ok) && $stable(int_value)))
    else $error("stalled result changed");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without an output stall");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(char_code)))
    else $error("waiting input transfer changed");

endmodule

bind decimal_ascii_to_signed_int dasi_checker u_dasi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .char_code    (char_code),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .ok           (ok),
  .int_value    (int_value)
);
`default_nettype wire
